FILE: design/bfmc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the box filter mipmap chain.
// No dependencies; used by the core and the bench.

package bfmc_pkg;

	localparam int unsigned CFG_W        = 13;
	localparam int unsigned CH_W         = 8;
	localparam int unsigned NUM_CH       = 4;
	localparam int unsigned PIX_W        = CH_W * NUM_CH;
	localparam int unsigned SUM_W        = CH_W + 1;
	localparam int unsigned PAIR_W       = SUM_W * NUM_CH;
	localparam int unsigned OUT_LEVEL_W  = 4;
	localparam int unsigned OUT_X_W      = 11;
	localparam int unsigned OUT_Y_W      = 11;
	localparam int unsigned IN_TDATA_W   = PIX_W;
	localparam int unsigned OUT_FIELDS_W = OUT_LEVEL_W + OUT_X_W + OUT_Y_W + PIX_W;
	localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

	localparam int unsigned MIN_SIDE     = 4;
	localparam int unsigned MIN_SRC_SIDE = 8;

	localparam int unsigned DEF_MAX_WIDTH  = 4096;
	localparam int unsigned DEF_MAX_HEIGHT = 4096;
	localparam int unsigned DEF_MAX_LEVELS = 10;

	localparam logic [CFG_W-1:0] RST_IMAGE_WIDTH  = CFG_W'(256);
	localparam logic [CFG_W-1:0] RST_IMAGE_HEIGHT = CFG_W'(256);

	typedef enum logic [1:0] {
		CFG_IMAGE_WIDTH  = 2'd0,
		CFG_IMAGE_HEIGHT = 2'd1,
		CFG_MIP_ENABLE   = 2'd2,
		CFG_TWO_CHANNEL  = 2'd3
	} cfg_index_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_AVG
	} state_t;

endpackage

FILE: design/bfmc_line_mem.sv
`timescale 1ns / 1ps
// Single-port synchronous line memory holding the even-row pair sums of all levels.
// Read data is registered, available in the cycle after the read enable; no dependencies.

module bfmc_line_mem #(
	parameter int unsigned DEPTH  = 4096,
	parameter int unsigned ADDR_W = 12,
	parameter int unsigned DATA_W = 36
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [ADDR_W-1:0] addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

FILE: design/box_filter_mipmap_chain_core.sv
`timescale 1ns / 1ps
// Streaming 2x2 box filter mipmap chain: level-zero pixels in, all lower levels out.
// Depends on bfmc_pkg and bfmc_line_mem.
//
// Channel   Direction  Handshake                   Payload
// s_axis    in         s_axis_tvalid/tready        tdata: c0, c1, c2, c3
// m_axis    out        m_axis_tvalid/tready        tdata: level, x, y, c0..c3; tlast
// cfg       in         cfg_we (no wait)            cfg_index, cfg_data
//
// An input pixel is taken in ST_IDLE and makes one level step in ST_STEP; each result of its
// cascade adds ST_AVG, after the registered read of the line memory, and another level step.
// A stalled output holds the level sequencer before its next step.
// Reset clears the counters and loads the default configuration; the line memory is not cleared.

module box_filter_mipmap_chain_core #(
	parameter int unsigned MAX_WIDTH  = bfmc_pkg::DEF_MAX_WIDTH,
	parameter int unsigned MAX_HEIGHT = bfmc_pkg::DEF_MAX_HEIGHT,
	parameter int unsigned MAX_LEVELS = bfmc_pkg::DEF_MAX_LEVELS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// c0, c1, c2, c3 (8 bits each) from bit 0 up.
	input  logic [bfmc_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_level (4), out_x (11), out_y (11), c0, c1, c2, c3 (8 each), zero pad.
	output logic [bfmc_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast,
	input  logic                                cfg_we,
	input  bfmc_pkg::cfg_index_t                cfg_index,
	input  logic [bfmc_pkg::CFG_W-1:0]          cfg_data
);

	import bfmc_pkg::*;

	localparam int unsigned CW   = $clog2(MAX_WIDTH);
	localparam int unsigned RCW  = $clog2(MAX_HEIGHT);
	localparam int unsigned WDW  = $clog2(MAX_WIDTH + 1);
	localparam int unsigned HDW  = $clog2(MAX_HEIGHT + 1);
	localparam int unsigned WCLW = (WDW > CFG_W) ? WDW : CFG_W;
	localparam int unsigned HCLW = (HDW > CFG_W) ? HDW : CFG_W;
	localparam int unsigned LW   = $clog2(MAX_LEVELS + 1);
	localparam int unsigned HIW  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
	localparam int unsigned AW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	state_t state_q, state_nxt;

	logic [CFG_W-1:0] image_width_q, image_height_q;
	logic             mip_enable_q, two_channel_q;

	logic [CW-1:0]  col_q [MAX_LEVELS+1];
	logic [RCW-1:0] row_q [MAX_LEVELS+1];
	logic [PIX_W-1:0] held_q [MAX_LEVELS];

	logic [LW-1:0]     s_q;
	logic [WDW-1:0]    cur_w_q;
	logic [HDW-1:0]    cur_h_q;
	logic [PIX_W-1:0]  px_q;
	logic [PAIR_W-1:0] pair_q;
	logic [CW-2:0]     dx_q;
	logic [RCW-2:0]    dy_q;

	logic                   pend_valid_q;
	logic [OUT_LEVEL_W-1:0] pend_level_q;
	logic [OUT_X_W-1:0]     pend_x_q;
	logic [OUT_Y_W-1:0]     pend_y_q;

	logic                   out_valid_q;
	logic                   out_last_q;
	logic [OUT_TDATA_W-1:0] out_data_q;

	logic in_accept, out_free, step_go, held_we, mem_we, mem_re, out_load;

	logic [CW-1:0]    col_cur;
	logic [RCW-1:0]   row_cur;
	logic             col_wrap, row_wrap;
	logic [CW-2:0]    dx;
	logic [RCW-2:0]   dy;
	logic             src_ok, is_left, is_top, produce;
	logic [PIX_W-1:0] held_cur;
	logic [PAIR_W-1:0] pair;
	logic [PAIR_W-1:0] mem_rdata;
	logic [PIX_W-1:0] avg;
	logic [AW-1:0]    mem_addr;
	logic [WCLW-1:0]  w_ext;
	logic [HCLW-1:0]  h_ext;
	logic [WDW-1:0]   w_clamped;
	logic [HDW-1:0]   h_clamped;
	logic [PIX_W-1:0] in_px;

	// Dimension clamping of the level-zero size.
	always_comb begin
		w_ext = WCLW'(image_width_q);
		h_ext = HCLW'(image_height_q);
		if (w_ext < WCLW'(MIN_SIDE)) begin
			w_clamped = WDW'(MIN_SIDE);
		end else if (w_ext > WCLW'(MAX_WIDTH)) begin
			w_clamped = WDW'(MAX_WIDTH);
		end else begin
			w_clamped = WDW'(w_ext);
		end
		if (h_ext < HCLW'(MIN_SIDE)) begin
			h_clamped = HDW'(MIN_SIDE);
		end else if (h_ext > HCLW'(MAX_HEIGHT)) begin
			h_clamped = HDW'(MAX_HEIGHT);
		end else begin
			h_clamped = HDW'(h_ext);
		end
	end

	always_comb begin
		in_px = s_axis_tdata;
		if (two_channel_q) begin
			in_px[PIX_W-1:2*CH_W] = '0;
		end
	end

	// Level step and averaging datapath.
	always_comb begin
		col_cur  = col_q[s_q];
		row_cur  = row_q[s_q];
		held_cur = held_q[HIW'(s_q)];
		col_wrap = (WDW'(col_cur) + WDW'(1)) >= cur_w_q;
		row_wrap = (HDW'(row_cur) + HDW'(1)) >= cur_h_q;
		dx       = col_cur[CW-1:1];
		dy       = row_cur[RCW-1:1];
		src_ok   = mip_enable_q && (s_q < LW'(MAX_LEVELS))
			&& (cur_w_q >= WDW'(MIN_SRC_SIDE)) && (cur_h_q >= HDW'(MIN_SRC_SIDE))
			&& (WDW'(dx) < (cur_w_q >> 1)) && (HDW'(dy) < (cur_h_q >> 1));
		is_left  = src_ok && !col_cur[0];
		is_top   = src_ok && col_cur[0] && !row_cur[0];
		produce  = src_ok && col_cur[0] && row_cur[0];
		for (int c = 0; c < NUM_CH; c++) begin
			pair[c*SUM_W +: SUM_W] = SUM_W'(held_cur[c*CH_W +: CH_W])
				+ SUM_W'(px_q[c*CH_W +: CH_W]);
		end
		mem_addr = AW'(32'(MAX_WIDTH) - (32'(MAX_WIDTH) >> s_q) + 32'(dx));
		for (int c = 0; c < NUM_CH; c++) begin
			avg[c*CH_W +: CH_W] = CH_W'(((SUM_W + 1)'(mem_rdata[c*SUM_W +: SUM_W])
				+ (SUM_W + 1)'(pair_q[c*SUM_W +: SUM_W])) >> 2);
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_accept) begin
					state_nxt = ST_STEP;
				end
			end
			ST_STEP: begin
				if (step_go) begin
					state_nxt = produce ? ST_AVG : ST_IDLE;
				end
			end
			ST_AVG: begin
				state_nxt = ST_STEP;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		out_free      = !out_valid_q || m_axis_tready;
		s_axis_tready = (state_q == ST_IDLE);
		in_accept     = s_axis_tvalid && s_axis_tready;
		step_go       = (state_q == ST_STEP) && (!pend_valid_q || out_free);
		held_we       = step_go && is_left;
		mem_we        = step_go && is_top;
		mem_re        = step_go && produce;
		out_load      = step_go && pend_valid_q;
	end

	bfmc_line_mem #(
		.DEPTH  (MAX_WIDTH),
		.ADDR_W (AW),
		.DATA_W (PAIR_W)
	) u_line_mem (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (pair),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			mip_enable_q   <= 1'b1;
			two_channel_q  <= 1'b0;
			for (int i = 0; i <= MAX_LEVELS; i++) begin
				col_q[i] <= '0;
				row_q[i] <= '0;
			end
		end else begin
			if (step_go) begin
				if (col_wrap) begin
					col_q[s_q] <= '0;
					row_q[s_q] <= row_wrap ? '0 : row_cur + RCW'(1);
				end else begin
					col_q[s_q] <= col_cur + CW'(1);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_IMAGE_WIDTH, CFG_IMAGE_HEIGHT: begin
						if (cfg_index == CFG_IMAGE_WIDTH) begin
							image_width_q <= cfg_data;
						end else begin
							image_height_q <= cfg_data;
						end
						for (int i = 0; i <= MAX_LEVELS; i++) begin
							col_q[i] <= '0;
							row_q[i] <= '0;
						end
					end
					CFG_MIP_ENABLE: begin
						mip_enable_q <= cfg_data[0];
					end
					CFG_TWO_CHANNEL: begin
						two_channel_q <= cfg_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			s_q          <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (in_accept) begin
				s_q          <= '0;
				pend_valid_q <= 1'b0;
			end else if (state_q == ST_AVG) begin
				s_q          <= s_q + LW'(1);
				pend_valid_q <= 1'b1;
			end else if (step_go) begin
				pend_valid_q <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_q    <= in_px;
			cur_w_q <= w_clamped;
			cur_h_q <= h_clamped;
		end else if (state_q == ST_AVG) begin
			px_q         <= avg;
			cur_w_q      <= cur_w_q >> 1;
			cur_h_q      <= cur_h_q >> 1;
			pend_level_q <= OUT_LEVEL_W'(32'(s_q) + 32'd1);
			pend_x_q     <= OUT_X_W'(dx_q);
			pend_y_q     <= OUT_Y_W'(dy_q);
		end
		if (held_we) begin
			held_q[HIW'(s_q)] <= px_q;
		end
		if (mem_re) begin
			pair_q <= pair;
			dx_q   <= dx;
			dy_q   <= dy;
		end
		if (out_load) begin
			out_data_q <= OUT_TDATA_W'({px_q, pend_y_q, pend_x_q, pend_level_q});
			out_last_q <= !produce;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tlast  = out_last_q;

	a_read_then_avg: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |=> (state_q == ST_AVG))
		else $error("line memory read not followed by the averaging cycle");

	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_valid_q)
		else $error("pending result left behind at the end of a cascade");

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		s_q <= LW'(MAX_LEVELS))
		else $error("level index beyond the deepest level");

	a_one_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("line memory read and write in the same cycle");

	a_load_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_axis_tready) |-> !out_load)
		else $error("output register overwritten while a transfer is pending");

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for box_filter_mipmap_chain_core: streams pixel frames of many sizes
// and modes, predicts every lower mip level pixel and checks each output transfer in order.
// Depends on bfmc_pkg and the core RTL.

import bfmc_pkg::*;

typedef struct packed {
	logic [OUT_LEVEL_W-1:0]         level;
	logic [OUT_X_W-1:0]             x;
	logic [OUT_Y_W-1:0]             y;
	logic [NUM_CH-1:0][CH_W-1:0]    ch;
	logic                           last;
} mip_px_t;

class mip_scoreboard;
	localparam int unsigned X_LSB = OUT_LEVEL_W;
	localparam int unsigned Y_LSB = X_LSB + OUT_X_W;
	localparam int unsigned C_LSB = Y_LSB + OUT_Y_W;

	int unsigned width_reg  = 256;
	int unsigned height_reg = 256;
	bit          mip_on     = 1'b1;
	bit          two_ch     = 1'b0;

	bit [SUM_W-1:0] pair_sum [DEF_MAX_LEVELS][DEF_MAX_WIDTH/2][NUM_CH];
	bit [CH_W-1:0]  held_px [DEF_MAX_LEVELS][NUM_CH];
	int unsigned    lvl_col [DEF_MAX_LEVELS+1];
	int unsigned    lvl_row [DEF_MAX_LEVELS+1];

	mip_px_t     expected_mips[$];
	int unsigned errors;
	int unsigned pixels_in;
	int unsigned mips_out;
	int unsigned deepest;

	function void restart_frame();
		foreach (lvl_col[i]) begin
			lvl_col[i] = 0;
			lvl_row[i] = 0;
		end
	endfunction

	function void write_reg(cfg_index_t idx, int unsigned val);
		case (idx)
			CFG_IMAGE_WIDTH: begin
				width_reg = val;
				restart_frame();
			end
			CFG_IMAGE_HEIGHT: begin
				height_reg = val;
				restart_frame();
			end
			CFG_MIP_ENABLE: mip_on = val[0];
			CFG_TWO_CHANNEL: two_ch = val[0];
			default: ;
		endcase
	endfunction

	function int unsigned side(int unsigned v, int unsigned lim);
		if (v < MIN_SIDE)
			return MIN_SIDE;
		if (v > lim)
			return lim;
		return v;
	endfunction

	function void note_pixel(bit [PIX_W-1:0] data);
		int unsigned w, h, s, col, row, dx, dy, n, c;
		bit [CH_W-1:0]  px [NUM_CH];
		bit [SUM_W-1:0] pr [NUM_CH];
		mip_px_t        pend;
		w = side(width_reg, DEF_MAX_WIDTH);
		h = side(height_reg, DEF_MAX_HEIGHT);
		s = 0;
		n = 0;
		pixels_in++;
		for (c = 0; c < NUM_CH; c++)
			px[c] = data[c*CH_W +: CH_W];
		if (two_ch) begin
			px[2] = '0;
			px[3] = '0;
		end
		while (1) begin
			col = lvl_col[s];
			row = lvl_row[s];
			if (col + 1 >= w) begin
				lvl_col[s] = 0;
				lvl_row[s] = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				lvl_col[s] = col + 1;
			end
			if (!mip_on || s >= DEF_MAX_LEVELS || w < MIN_SRC_SIDE || h < MIN_SRC_SIDE)
				break;
			dx = col >> 1;
			dy = row >> 1;
			if (dx >= w / 2 || dy >= h / 2)
				break;
			if (col[0] == 1'b0) begin
				for (c = 0; c < NUM_CH; c++)
					held_px[s][c] = px[c];
				break;
			end
			for (c = 0; c < NUM_CH; c++)
				pr[c] = SUM_W'(held_px[s][c]) + SUM_W'(px[c]);
			if (row[0] == 1'b0) begin
				for (c = 0; c < NUM_CH; c++)
					pair_sum[s][dx][c] = pr[c];
				break;
			end
			for (c = 0; c < NUM_CH; c++)
				px[c] = CH_W'((int'(pair_sum[s][dx][c]) + int'(pr[c])) >> 2);
			if (n > 0)
				expected_mips.push_back(pend);
			pend.level = OUT_LEVEL_W'(s + 1);
			pend.x     = OUT_X_W'(dx);
			pend.y     = OUT_Y_W'(dy);
			for (c = 0; c < NUM_CH; c++)
				pend.ch[c] = px[c];
			pend.last  = 1'b0;
			n++;
			s++;
			w /= 2;
			h /= 2;
		end
		if (n > 0) begin
			pend.last = 1'b1;
			expected_mips.push_back(pend);
		end
		if (n > deepest)
			deepest = n;
	endfunction

	function void match_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	function void check_mip(logic [OUT_TDATA_W-1:0] data, logic last);
		mip_px_t want;
		int unsigned c;
		if (expected_mips.size() == 0) begin
			$error("output transfer with no pixel expected: tdata %h", data);
			errors++;
			return;
		end
		want = expected_mips.pop_front();
		mips_out++;
		match_field("out_level", 32'(want.level), 32'(data[OUT_LEVEL_W-1:0]));
		match_field("out_x", 32'(want.x), 32'(data[X_LSB +: OUT_X_W]));
		match_field("out_y", 32'(want.y), 32'(data[Y_LSB +: OUT_Y_W]));
		for (c = 0; c < NUM_CH; c++)
			match_field($sformatf("out_c%0d", c), 32'(want.ch[c]),
				32'(data[C_LSB + c*CH_W +: CH_W]));
		match_field("last_of_run", 32'(want.last), 32'(last));
	endfunction
endclass

module tb;
	localparam int unsigned IDLE_LIMIT    = 20000;
	localparam int unsigned SETTLE_CYCLES = 40;
	localparam int unsigned HOLD_CYCLES   = 1500;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   cfg_we;
	cfg_index_t             cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	mip_scoreboard sb = new();

	int unsigned burst_left;
	int unsigned gap_max;
	int unsigned ready_mode;
	int unsigned hold_len;
	int unsigned idle_cycles;
	int unsigned settings;
	logic [7:0]  ready_pat = 8'b1011_0010;

	box_filter_mipmap_chain_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_pixel(s_axis_tdata);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_mip(m_axis_tdata, m_axis_tlast);
		end
	end

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$error("no transfer for %0d cycles, %0d pixels still expected",
				IDLE_LIMIT, sb.expected_mips.size());
			$display("box_filter_mipmap_chain_core: mismatch");
			$finish;
		end
	end

	always begin
		@(negedge clk);
		if (hold_len != 0) begin
			m_axis_tready <= 1'b0;
			repeat (hold_len) @(negedge clk);
			hold_len = 0;
		end else begin
			case (ready_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: begin
					ready_pat = {ready_pat[6:0], ready_pat[7]};
					m_axis_tready <= ready_pat[0];
				end
			endcase
		end
	end

	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [PIX_W-1:0] p;
		int unsigned c;
		for (c = 0; c < NUM_CH; c++) begin
			case ($urandom_range(0, 7))
				0: p[c*CH_W +: CH_W] = '0;
				1: p[c*CH_W +: CH_W] = '1;
				default: p[c*CH_W +: CH_W] = CH_W'($urandom_range(0, 255));
			endcase
		end
		return p;
	endfunction

	task automatic send_pixel(logic [PIX_W-1:0] pix);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (gap_max != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat ($urandom_range(1, gap_max)) @(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= pix;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		@(negedge clk);
	endtask

	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (sb.expected_mips.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(cfg_index_t idx, int unsigned val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[CFG_W-1:0];
		sb.write_reg(idx, 32'(val[CFG_W-1:0]));
		@(negedge clk);
	endtask

	task automatic run_frame(int unsigned w, int unsigned h, bit mip, bit two,
			int unsigned count);
		settle();
		write_reg(CFG_MIP_ENABLE, 32'(mip));
		write_reg(CFG_TWO_CHANNEL, 32'(two));
		write_reg(CFG_IMAGE_WIDTH, w);
		write_reg(CFG_IMAGE_HEIGHT, h);
		cfg_we <= 1'b0;
		settings++;
		ready_mode = $urandom_range(0, 3);
		case ($urandom_range(0, 2))
			0: gap_max = 0;
			1: gap_max = 3;
			default: gap_max = 12;
		endcase
		repeat (count) send_pixel(rand_pixel());
	endtask

	initial begin
		logic [PIX_W-1:0] corner_px [16];
		corner_px = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
			32'hFEFFFFFF, 32'hFFFEFFFF, 32'h01010101, 32'h00000000,
			32'hFFFFFFFF, 32'hFFFFFFFF, 32'h00000000, 32'h00000000,
			32'hFFFFFFFE, 32'hFFFFFFFF, 32'h01010100, 32'h80FF0080};
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		m_axis_tready = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = CFG_IMAGE_WIDTH;
		cfg_data      = '0;
		ready_mode    = 0;
		gap_max       = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Full-scale, all-zero and rounding-down squares, then a frame with mips off.
		run_frame(8, 8, 1'b1, 1'b0, 0);
		foreach (corner_px[i])
			send_pixel(corner_px[i]);
		run_frame(8, 8, 1'b0, 1'b0, 8);

		run_frame(8, 8, 1'b1, 1'b0, 64);
		run_frame(9, 11, 1'b1, 1'b1, 99);

		// The receiver stops long enough for the core to back up onto its input.
		run_frame(16, 16, 1'b1, 1'b0, 0);
		hold_len = HOLD_CYCLES;
		repeat (64) send_pixel(rand_pixel());
		settle();
		write_reg(CFG_TWO_CHANNEL, 1);
		cfg_we <= 1'b0;
		repeat (32) send_pixel(rand_pixel());

		run_frame(0, 5, 1'b1, 1'b0, 8);
		run_frame(3, 8191, 1'b1, 1'b0, 8);
		run_frame(12, 20, 1'b0, 1'b1, 16);
		run_frame(10, 8, 1'b1, 1'b0, 24);
		run_frame(8191, 8, 1'b1, 1'b0, 8);
		run_frame(8, 8, 1'b1, 1'b1, 16);
		settle();

		$display("Streamed %0d pixels through %0d frame settings and checked %0d mip pixels,",
			sb.pixels_in, settings, sb.mips_out);
		$display("with cascades up to %0d levels deep; %0d field errors.",
			sb.deepest, sb.errors);
		if (sb.errors == 0)
			$display("box_filter_mipmap_chain_core: match");
		else
			$display("box_filter_mipmap_chain_core: mismatch");
		$finish;
	end
endmodule

FILE: files.f
design/bfmc_pkg.sv
design/bfmc_line_mem.sv
design/box_filter_mipmap_chain_core.sv
sim/tb.sv
